### src/vkcl_pkg.sv
package vkcl_pkg;

  // Entry length and derived widths
  localparam int CODE_DIGITS = 4;
  localparam int SHOWN_DIGITS = (CODE_DIGITS < 4) ? CODE_DIGITS : 4;
  localparam int COUNT_W = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int CODE_W = 4 * CODE_DIGITS;

  // Lock modes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_LISTEN   = 3'd1;
  localparam logic [2:0] MODE_PASSWORD = 3'd2;
  localparam logic [2:0] MODE_GRANTED  = 3'd3;
  localparam logic [2:0] MODE_DENIED   = 3'd4;

  // Event kinds
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_WAKE  = 3'd1;
  localparam logic [2:0] FUNC_OPEN  = 3'd2;
  localparam logic [2:0] FUNC_CLOSE = 3'd3;
  localparam logic [2:0] FUNC_KEY   = 3'd4;

  // Special keys
  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_OK         = 4'd10;
  localparam logic [3:0] KEY_DELETE     = 4'd11;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_PASS_CODE      = 2'd0;
  localparam logic [1:0] CFG_LISTEN_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_RESULT_HOLD    = 2'd2;

  localparam logic [15:0] PASS_CODE_RST      = 16'h1234;
  localparam logic [15:0] LISTEN_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] RESULT_HOLD_RST    = 16'd3000;

  typedef struct packed {
    logic [15:0] pass_code;
    logic [15:0] listen_timeout;
    logic [15:0] result_hold;
  } vkcl_cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  digit_count;
    logic [15:0] shown_digits;
    logic        grant_pulse;
    logic        deny_pulse;
  } vkcl_result_t;

endpackage

### src/vkcl_evt_if.sv
interface vkcl_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [3:0] key;

  modport source (output valid, output func, output key, input ready);
  modport sink (input valid, input func, input key, output ready);
endinterface

### src/vkcl_res_if.sv
interface vkcl_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [2:0]  digit_count;
  logic [15:0] shown_digits;
  logic        grant_pulse;
  logic        deny_pulse;

  modport source (output valid, output mode, output digit_count, output shown_digits,
                  output grant_pulse, output deny_pulse, input ready);
  modport sink (input valid, input mode, input digit_count, input shown_digits,
                input grant_pulse, input deny_pulse, output ready);
endinterface

### src/vkcl_cfg_if.sv
interface vkcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/vkcl_cfg_regs.sv
module vkcl_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  vkcl_cfg_if.sink           cfg,
  output vkcl_pkg::vkcl_cfg_t regs
);

  // Writes are always accepted
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pass_code      <= vkcl_pkg::PASS_CODE_RST;
      regs.listen_timeout <= vkcl_pkg::LISTEN_TIMEOUT_RST;
      regs.result_hold    <= vkcl_pkg::RESULT_HOLD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        vkcl_pkg::CFG_PASS_CODE:      regs.pass_code      <= cfg.data;
        vkcl_pkg::CFG_LISTEN_TIMEOUT: regs.listen_timeout <= cfg.data;
        vkcl_pkg::CFG_RESULT_HOLD:    regs.result_hold    <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

### src/vkcl_fsm.sv
module vkcl_fsm (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [2:0]             func,
  input  logic [3:0]             key,
  input  vkcl_pkg::vkcl_cfg_t    regs,
  output vkcl_pkg::vkcl_result_t result
);

  logic [2:0]                   mode;
  logic [2:0]                   mode_next;
  logic [15:0]                  elapsed;
  logic [15:0]                  elapsed_next;
  logic [3:0]                   entry [vkcl_pkg::CODE_DIGITS];
  logic [3:0]                   entry_next [vkcl_pkg::CODE_DIGITS];
  logic [vkcl_pkg::COUNT_W-1:0] count;
  logic [vkcl_pkg::COUNT_W-1:0] count_next;
  logic [15:0]                  elapsed_inc;
  logic [15:0]                  limit;
  logic                         match;
  logic [vkcl_pkg::CODE_W+15:0] code_ext;
  logic                         grant;
  logic                         deny;

  // Saturating tick count and the limit that applies in the current mode
  assign elapsed_inc = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;
  assign limit = (mode == vkcl_pkg::MODE_LISTEN) ? regs.listen_timeout : regs.result_hold;

  // Full-length match; code digits beyond the fourth compare against zero
  assign code_ext = {regs.pass_code, {vkcl_pkg::CODE_W{1'b0}}};
  always_comb begin
    match = (count == vkcl_pkg::COUNT_W'(vkcl_pkg::CODE_DIGITS));
    for (int i = 0; i < vkcl_pkg::CODE_DIGITS; i++) begin
      if (entry[i] != code_ext[vkcl_pkg::CODE_W + 15 - 4 * i -: 4]) begin
        match = 1'b0;
      end
    end
  end

  // Next-state logic for one event
  always_comb begin
    mode_next    = mode;
    elapsed_next = elapsed;
    entry_next   = entry;
    count_next   = count;
    grant        = 1'b0;
    deny         = 1'b0;
    unique case (func)
      vkcl_pkg::FUNC_TICK: begin
        if (mode == vkcl_pkg::MODE_LISTEN || mode == vkcl_pkg::MODE_GRANTED ||
            mode == vkcl_pkg::MODE_DENIED) begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc > limit) begin
            mode_next = vkcl_pkg::MODE_IDLE;
          end
        end
      end
      vkcl_pkg::FUNC_WAKE: begin
        if (mode == vkcl_pkg::MODE_IDLE) begin
          mode_next    = vkcl_pkg::MODE_LISTEN;
          elapsed_next = '0;
        end
      end
      vkcl_pkg::FUNC_OPEN: begin
        if (mode == vkcl_pkg::MODE_LISTEN) begin
          mode_next = vkcl_pkg::MODE_PASSWORD;
        end
      end
      vkcl_pkg::FUNC_CLOSE: begin
        if (mode == vkcl_pkg::MODE_LISTEN) begin
          mode_next = vkcl_pkg::MODE_IDLE;
        end
      end
      vkcl_pkg::FUNC_KEY: begin
        if (mode == vkcl_pkg::MODE_PASSWORD) begin
          // unused key codes fall through and are ignored
          if (key <= vkcl_pkg::KEY_LAST_DIGIT) begin
            if (count < vkcl_pkg::COUNT_W'(vkcl_pkg::CODE_DIGITS)) begin
              entry_next[count[vkcl_pkg::IDX_W-1:0]] = key;
              count_next = count + vkcl_pkg::COUNT_W'(1);
            end
          end else if (key == vkcl_pkg::KEY_DELETE) begin
            if (count != '0) begin
              count_next = count - vkcl_pkg::COUNT_W'(1);
              entry_next[count_next[vkcl_pkg::IDX_W-1:0]] = 4'd0;
            end
          end else if (key == vkcl_pkg::KEY_OK) begin
            if (match) begin
              mode_next = vkcl_pkg::MODE_GRANTED;
              grant     = 1'b1;
            end else begin
              mode_next = vkcl_pkg::MODE_DENIED;
              deny      = 1'b1;
            end
            elapsed_next = '0;
            count_next   = '0;
            for (int i = 0; i < vkcl_pkg::CODE_DIGITS; i++) begin
              entry_next[i] = 4'd0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Result fields from the state after the event
  always_comb begin
    result.mode         = mode_next;
    result.grant_pulse  = grant;
    result.deny_pulse   = deny;
    result.digit_count  = (count_next > vkcl_pkg::COUNT_W'(7)) ? 3'd7 : 3'(count_next);
    result.shown_digits = '0;
    for (int i = 0; i < vkcl_pkg::SHOWN_DIGITS; i++) begin
      if (vkcl_pkg::COUNT_W'(i) < count_next) begin
        result.shown_digits[15 - 4 * i -: 4] = entry_next[i];
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= vkcl_pkg::MODE_IDLE;
      elapsed <= '0;
      count   <= '0;
      for (int i = 0; i < vkcl_pkg::CODE_DIGITS; i++) begin
        entry[i] <= 4'd0;
      end
    end else if (step) begin
      mode    <= mode_next;
      elapsed <= elapsed_next;
      count   <= count_next;
      entry   <= entry_next;
    end
  end

endmodule

### src/voice_keypad_code_lock.sv
// Channel  Role  Payload
// evt      sink  func[2:0], key[3:0]
// res      src   mode, digit_count, shown_digits, grant_pulse, deny_pulse
// cfg      sink  index[1:0], data[15:0]
//
// One item per cycle while the result side is not stalled; each item passes through
// the input register, then the result register, before its result is valid.
// The lock state updates as an item moves from the input register into the result register.
// rst is synchronous, active high: mode idle, entry empty, registers at defaults.
// A stalled result holds the result register; the input register still takes
// one more item, after which evt.ready drops. Config writes are always accepted.
module voice_keypad_code_lock (
  input logic       clk,
  input logic       rst,
  vkcl_evt_if.sink  evt,
  vkcl_res_if.source res,
  vkcl_cfg_if.sink  cfg
);

  vkcl_pkg::vkcl_cfg_t    regs;
  vkcl_pkg::vkcl_result_t result;
  logic                   s1_valid;
  logic [2:0]             s1_func;
  logic [3:0]             s1_key;
  logic                   res_valid;
  vkcl_pkg::vkcl_result_t res_data;
  logic                   step;

  // Item moves forward when the result register is free or being drained
  assign step      = s1_valid && (!res_valid || res.ready);
  assign evt.ready = !s1_valid || step;

  vkcl_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  vkcl_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .func   (s1_func),
    .key    (s1_key),
    .regs   (regs),
    .result (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      s1_func <= evt.func;
      s1_key  <= evt.key;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_data <= result;
    end
  end

  assign res.valid        = res_valid;
  assign res.mode         = res_data.mode;
  assign res.digit_count  = res_data.digit_count;
  assign res.shown_digits = res_data.shown_digits;
  assign res.grant_pulse  = res_data.grant_pulse;
  assign res.deny_pulse   = res_data.deny_pulse;

`ifndef SYNTHESIS
  a_grant_mode: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.grant_pulse |-> res.mode == vkcl_pkg::MODE_GRANTED)
    else $error("grant pulse without granted mode");

  a_deny_mode: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.deny_pulse |-> res.mode == vkcl_pkg::MODE_DENIED && !res.grant_pulse)
    else $error("deny pulse without denied mode");

  a_verdict_clears: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.grant_pulse || res.deny_pulse) |->
      res.digit_count == 3'd0 && res.shown_digits == 16'd0)
    else $error("entry not cleared on verdict");

  a_entry_outside_password: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.digit_count != 3'd0 |-> res.mode == vkcl_pkg::MODE_PASSWORD)
    else $error("digits held outside password mode");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_valid && !res.ready |=> s1_valid && $stable(s1_func) && $stable(s1_key))
    else $error("input register lost an item during stall");
`endif

endmodule

### tb/vkcl_checker.sv
`timescale 1ns / 1ps

// Watches the event, result and register channels of the code lock, keeps its
// own copy of the lock state and registers, and checks every result in order.
module vkcl_checker
  import vkcl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  vkcl_evt_if  evt,
  vkcl_res_if  res,
  vkcl_cfg_if  cfg,
  output int   error_count,
  output int   pending
);

  // Register copies
  logic [15:0] code_reg;
  logic [15:0] listen_limit;
  logic [15:0] hold_limit;

  // Lock state copy
  logic [2:0]  lock_mode;
  logic [15:0] elapsed;
  logic [3:0]  entry_digit [CODE_DIGITS];
  int          entry_len;

  vkcl_result_t lock_expect_q [$];
  int           errs = 0;

  assign error_count = errs;

  task automatic note_error(input string msg);
    errs++;
    if (errs <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic void clear_entry();
    foreach (entry_digit[i]) entry_digit[i] = '0;
    entry_len = 0;
  endfunction

  // Apply one event to the lock copy and queue the result it produces
  task automatic predict_lock_event(input logic [2:0] f, input logic [3:0] k);
    logic [15:0]  limit;
    logic [3:0]   want;
    logic         hit;
    int           i;
    vkcl_result_t r;
    r = '0;
    case (f)
      FUNC_TICK: begin
        // timer runs only while listening or showing a verdict
        if (lock_mode == MODE_LISTEN || lock_mode == MODE_GRANTED ||
            lock_mode == MODE_DENIED) begin
          limit = (lock_mode == MODE_LISTEN) ? listen_limit : hold_limit;
          if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
          if (elapsed > limit) lock_mode = MODE_IDLE;
        end
      end
      FUNC_WAKE: begin
        if (lock_mode == MODE_IDLE) begin
          lock_mode = MODE_LISTEN;
          elapsed = '0;
        end
      end
      FUNC_OPEN: begin
        if (lock_mode == MODE_LISTEN) lock_mode = MODE_PASSWORD;
      end
      FUNC_CLOSE: begin
        if (lock_mode == MODE_LISTEN) lock_mode = MODE_IDLE;
      end
      FUNC_KEY: begin
        if (lock_mode == MODE_PASSWORD) begin
          if (k <= KEY_LAST_DIGIT) begin
            // digits past a full entry are dropped
            if (entry_len < CODE_DIGITS) begin
              entry_digit[entry_len] = k;
              entry_len++;
            end
          end else if (k == KEY_DELETE) begin
            if (entry_len > 0) begin
              entry_len--;
              entry_digit[entry_len] = '0;
            end
          end else if (k == KEY_OK) begin
            // full-length exact match only; digits past the fourth must be zero
            hit = (entry_len == CODE_DIGITS);
            for (i = 0; i < CODE_DIGITS; i++) begin
              want = (i < 4) ? 4'(code_reg >> (4 * (3 - i))) : 4'd0;
              if (entry_digit[i] != want) hit = 1'b0;
            end
            if (hit) begin
              lock_mode = MODE_GRANTED;
              r.grant_pulse = 1'b1;
            end else begin
              lock_mode = MODE_DENIED;
              r.deny_pulse = 1'b1;
            end
            elapsed = '0;
            clear_entry();
          end
        end
      end
      default: ;
    endcase
    r.mode = lock_mode;
    r.digit_count = (entry_len > 7) ? 3'd7 : 3'(entry_len);
    for (i = 0; i < SHOWN_DIGITS; i++) begin
      if (i < entry_len) r.shown_digits[4 * (3 - i) +: 4] = entry_digit[i];
    end
    lock_expect_q.push_back(r);
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk) begin : watch
    vkcl_result_t got;
    vkcl_result_t want;
    if (rst) begin
      code_reg     = PASS_CODE_RST;
      listen_limit = LISTEN_TIMEOUT_RST;
      hold_limit   = RESULT_HOLD_RST;
      lock_mode    = MODE_IDLE;
      elapsed      = '0;
      clear_entry();
      lock_expect_q.delete();
    end else begin
      // result items against the oldest prediction
      if (res.valid && res.ready) begin
        got.mode         = res.mode;
        got.digit_count  = res.digit_count;
        got.shown_digits = res.shown_digits;
        got.grant_pulse  = res.grant_pulse;
        got.deny_pulse   = res.deny_pulse;
        if (lock_expect_q.size() == 0) begin
          note_error($sformatf("unexpected result: mode=%0d count=%0d shown=%h grant=%0b deny=%0b",
                               got.mode, got.digit_count, got.shown_digits,
                               got.grant_pulse, got.deny_pulse));
        end else begin
          want = lock_expect_q.pop_front();
          if (got.mode !== want.mode || got.digit_count !== want.digit_count ||
              got.shown_digits !== want.shown_digits ||
              got.grant_pulse !== want.grant_pulse || got.deny_pulse !== want.deny_pulse) begin
            note_error($sformatf({"mismatch: expected mode=%0d count=%0d shown=%h grant=%0b ",
                                  "deny=%0b, got mode=%0d count=%0d shown=%h grant=%0b deny=%0b"},
                                 want.mode, want.digit_count, want.shown_digits,
                                 want.grant_pulse, want.deny_pulse,
                                 got.mode, got.digit_count, got.shown_digits,
                                 got.grant_pulse, got.deny_pulse));
          end
        end
      end
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_PASS_CODE:      code_reg = cfg.data;
          CFG_LISTEN_TIMEOUT: listen_limit = cfg.data;
          CFG_RESULT_HOLD:    hold_limit = cfg.data;
          default: ;
        endcase
      end
      // event items
      if (evt.valid && evt.ready) begin
        predict_lock_event(evt.func, evt.key);
      end
    end
    pending <= lock_expect_q.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

// Drives events and register writes into the code lock with random gaps and
// result stalls; the checker beside the block does all the predicting.
module tb_top;
  import vkcl_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk;
  logic        rst;
  logic        steady;
  int          cycles = 0;
  int          sent = 0;
  int          error_count;
  int          pending;
  logic [15:0] code_now;
  logic [15:0] listen_now;
  logic [15:0] hold_now;

  vkcl_evt_if evt_ch ();
  vkcl_res_if res_ch ();
  vkcl_cfg_if cfg_ch ();

  voice_keypad_code_lock dut (
    .clk (clk),
    .rst (rst),
    .evt (evt_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  vkcl_checker lock_monitor (
    .clk         (clk),
    .rst         (rst),
    .evt         (evt_ch),
    .res         (res_ch),
    .cfg         (cfg_ch),
    .error_count (error_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("voice_keypad_code_lock regression: fail");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [3:0] any_key();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [15:0] random_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
            4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // Result side back-pressure
  initial begin
    int n;
    res_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      n = pick_gap();
      if (rst || n == 0) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  // One event item; valid stays high afterwards until the next call decides
  task automatic push_event(input logic [2:0] f, input logic [3:0] k);
    int g;
    g = pick_gap();
    if (g > 0) begin
      evt_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.func  <= f;
    evt_ch.key   <= k;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Register write; the caller lowers valid after the last one
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every result is back
  task automatic settle();
    evt_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Wake, listen, enter a code, confirm, then send random ticks while the verdict shows
  task automatic run_sequence();
    int         n;
    int         r;
    int         i;
    int         slip;
    logic [3:0] d;
    // bring the lock back to idle from any mode
    if (hold_now <= 16'd64) begin
      push_event(FUNC_KEY, KEY_OK);
      push_event(FUNC_CLOSE, any_key());
      repeat (int'(hold_now) + 1) push_event(FUNC_TICK, any_key());
    end
    push_event(FUNC_WAKE, any_key());
    n = (listen_now <= 16'd40) ? $urandom_range(0, int'(listen_now) + 1) : $urandom_range(0, 3);
    repeat (n) push_event(FUNC_TICK, any_key());
    r = $urandom_range(0, 19);
    if (r < 2) push_event(FUNC_CLOSE, any_key());
    else if (r < 19) push_event(FUNC_OPEN, any_key());
    r = $urandom_range(0, 9);
    if (r < 4) begin
      // the stored code, with an occasional typo fixed by delete
      for (i = 0; i < 4; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          push_event(FUNC_KEY, 4'($urandom_range(0, 9)));
          push_event(FUNC_KEY, KEY_DELETE);
        end
        push_event(FUNC_KEY, code_now[4 * (3 - i) +: 4]);
      end
      if ($urandom_range(0, 3) == 0) push_event(FUNC_KEY, 4'($urandom_range(0, 9)));
    end else if (r < 6) begin
      // one digit off
      slip = $urandom_range(0, 3);
      for (i = 0; i < 4; i++) begin
        d = code_now[4 * (3 - i) +: 4];
        if (i == slip) d = (d >= 4'd9) ? 4'd0 : d + 4'd1;
        push_event(FUNC_KEY, d);
      end
    end else begin
      // random entry with deletes and stray ticks
      n = $urandom_range(0, 7);
      repeat (n) begin
        r = $urandom_range(0, 9);
        if (r < 2) push_event(FUNC_KEY, KEY_DELETE);
        else if (r < 3) push_event(FUNC_TICK, any_key());
        else push_event(FUNC_KEY, 4'($urandom_range(0, 9)));
      end
    end
    push_event(FUNC_KEY, KEY_OK);
    n = (hold_now <= 16'd40) ? $urandom_range(0, int'(hold_now) + 1) : $urandom_range(0, 3);
    repeat (n) push_event(FUNC_TICK, any_key());
  endtask

  // Stimulus
  initial begin
    int p;
    int target;
    rst          <= 1'b1;
    steady       <= 1'b0;
    evt_ch.valid <= 1'b0;
    evt_ch.func  <= FUNC_TICK;
    evt_ch.key   <= 4'd0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_PASS_CODE;
    cfg_ch.data  <= 16'd0;
    code_now   = PASS_CODE_RST;
    listen_now = LISTEN_TIMEOUT_RST;
    hold_now   = RESULT_HOLD_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: ignored events, unused codes, full entry, empty delete, grant
    push_event(FUNC_TICK, 4'd0);
    push_event(FUNC_OPEN, 4'd0);
    push_event(FUNC_KEY, 4'd5);
    push_event(FUNC_WAKE, 4'd0);
    push_event(FUNC_WAKE, 4'd15);
    push_event(FUNC_TICK, 4'd0);
    push_event(FUNC_KEY, 4'd3);
    push_event(3'd5, 4'd0);
    push_event(3'd7, 4'd15);
    push_event(FUNC_OPEN, 4'd0);
    push_event(FUNC_WAKE, 4'd0);
    push_event(FUNC_TICK, 4'd0);
    push_event(FUNC_KEY, KEY_DELETE);
    push_event(FUNC_KEY, 4'd12);
    push_event(FUNC_KEY, 4'd15);
    push_event(FUNC_KEY, 4'd1);
    push_event(FUNC_KEY, 4'd2);
    push_event(FUNC_KEY, 4'd3);
    push_event(FUNC_KEY, 4'd4);
    push_event(FUNC_KEY, 4'd9);
    push_event(FUNC_KEY, KEY_DELETE);
    push_event(FUNC_KEY, 4'd4);
    push_event(FUNC_KEY, KEY_OK);

    // random phases, each under its own register setting
    for (p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin code_now = PASS_CODE_RST; listen_now = 16'd3; hold_now = 16'd2; end
        1: begin code_now = 16'h0000; listen_now = 16'd0; hold_now = 16'd0; end
        2: begin code_now = 16'h9999; listen_now = 16'd15; hold_now = 16'd9; end
        3: begin code_now = 16'hFFFF; listen_now = 16'd1; hold_now = 16'd1; end
        4: begin code_now = 16'h5678; listen_now = 16'hFFFF; hold_now = 16'hFFFF; end
        5: begin
          code_now   = random_bcd();
          listen_now = 16'($urandom_range(0, 20));
          hold_now   = 16'($urandom_range(0, 20));
        end
        6: begin code_now = 16'($urandom_range(0, 65535)); listen_now = 16'd7; hold_now = 16'd3; end
        default: begin
          code_now   = random_bcd();
          listen_now = 16'($urandom_range(0, 40));
          hold_now   = 16'($urandom_range(0, 40));
        end
      endcase
      write_reg(CFG_PASS_CODE, code_now);
      write_reg(CFG_LISTEN_TIMEOUT, listen_now);
      write_reg(CFG_RESULT_HOLD, hold_now);
      cfg_ch.valid <= 1'b0;
      target = sent + ((p == 4) ? 60 : 200);
      while (sent < target) begin
        steady <= ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 7) == 0) begin
          // noise burst over all codes
          repeat ($urandom_range(1, 5)) push_event(3'($urandom_range(0, 7)), any_key());
        end else begin
          run_sequence();
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("voice_keypad_code_lock regression: pass");
    end else begin
      $display("voice_keypad_code_lock regression: fail");
    end
    $finish;
  end

endmodule
